// ----- src/nstg_pkg.sv -----
// ----------------------------------------------------------------------------
// nstg_pkg
// Shared types, constants and the quarter-wave sine table of the note
// sequencer tone generator.
// ----------------------------------------------------------------------------
package nstg_pkg;

  localparam int MAX_NOTES    = 64;
  localparam int NOTE_AW      = $clog2(MAX_NOTES);
  localparam int NOTE_CW      = NOTE_AW + 1;
  localparam int SAMPLE_WIDTH = 16;
  localparam int STEP_W       = 24;
  localparam int LEN_W        = 20;
  localparam int CNT_W        = 26;
  localparam int ENV_W        = 16;
  localparam int MAG_W        = SAMPLE_WIDTH - 1;
  localparam int QUARTER      = 256;
  localparam int QIDX_W       = 9;
  localparam int MUL_W        = 24;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int REM_W        = LEN_W + 1;
  localparam int DIV_STEPS    = 15;
  localparam int DCNT_W       = 4;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(32768);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint Q30_ONE = 64'sd1073741824;

  localparam logic [1:0] REG_NOTE_COUNT  = 2'd0;
  localparam logic [1:0] REG_ATTACK_GAIN = 2'd1;
  localparam logic [1:0] REG_DECAY_GAIN  = 2'd2;

  typedef logic [MAG_W-1:0] sine_lut_t [0:QUARTER];

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WR,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_MUL_PHASE,
    OP_MUL_ATTACK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_DECAY,
    OP_MUL_VOL,
    OP_MUL_SAMPLE,
    OP_FIN,
    OP_FAIL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic iter_last;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  function automatic longint unsigned shift_sub_div(input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sine_lut_t build_sine();
    sine_lut_t t;
    longint unsigned frac;
    longint unsigned x;
    longint unsigned term;
    longint unsigned mag;
    longint sum;
    for (int j = 0; j <= QUARTER; j++) begin
      frac = longint'(j) << 14;
      x = (frac * HALF_PI_Q30) >> 22;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = shift_sub_div(term, longint'((2 * k) * (2 * k + 1)));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > Q30_ONE) sum = Q30_ONE;
      mag = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      t[j] = mag[MAG_W-1:0];
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

// ----- src/nstg_ctrl.sv -----
// ----------------------------------------------------------------------------
// nstg_ctrl
// Sequencer of the tone generator: note scan, shared multiplier and divider
// steps, result hand-off.
// ----------------------------------------------------------------------------
module nstg_ctrl import nstg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_RD   = 14'b00000000000010,
    ST_CMP  = 14'b00000000000100,
    ST_MPH  = 14'b00000000001000,
    ST_MA   = 14'b00000000010000,
    ST_DA0  = 14'b00000000100000,
    ST_DA   = 14'b00000001000000,
    ST_MD   = 14'b00000010000000,
    ST_DD0  = 14'b00000100000000,
    ST_DD   = 14'b00001000000000,
    ST_MV   = 14'b00010000000000,
    ST_MS   = 14'b00100000000000,
    ST_FIN  = 14'b01000000000000,
    ST_FAIL = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            cmd.op = OP_SCAN_INIT;
            state_nxt = ST_RD;
          end else begin
            cmd.op = OP_WR;
          end
        end
      end
      ST_RD: begin
        cmd.op = OP_SCAN_RD;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op = OP_SCAN_CMP;
        if (stat.found) state_nxt = ST_MPH;
        else if (stat.iter_last) state_nxt = ST_FAIL;
        else state_nxt = ST_RD;
      end
      ST_MPH: begin
        cmd.op = OP_MUL_PHASE;
        state_nxt = ST_MA;
      end
      ST_MA: begin
        cmd.op = OP_MUL_ATTACK;
        state_nxt = ST_DA0;
      end
      ST_DA0: begin
        cmd.op = OP_DIV_INIT;
        state_nxt = ST_DA;
      end
      ST_DA: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_nxt = ST_MD;
      end
      ST_MD: begin
        cmd.op = OP_MUL_DECAY;
        state_nxt = ST_DD0;
      end
      ST_DD0: begin
        cmd.op = OP_DIV_INIT;
        state_nxt = ST_DD;
      end
      ST_DD: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_nxt = ST_MV;
      end
      ST_MV: begin
        cmd.op = OP_MUL_VOL;
        state_nxt = ST_MS;
      end
      ST_MS: begin
        cmd.op = OP_MUL_SAMPLE;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (!stat.out_busy) begin
          cmd.op = OP_FAIL;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- src/nstg_dp.sv -----
// ----------------------------------------------------------------------------
// nstg_dp
// Datapath of the tone generator: note stores, play position, registers,
// shared multiplier, serial divider, sine table and output register.
// ----------------------------------------------------------------------------
module nstg_dp import nstg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [NOTE_AW-1:0]      in_note_index,
  input  logic [STEP_W-1:0]       in_phase_step,
  input  logic [LEN_W-1:0]        in_note_length,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample
);

  logic [STEP_W-1:0] step_mem [MAX_NOTES];
  logic [LEN_W-1:0]  len_mem  [MAX_NOTES];

  logic [6:0] note_count_r;
  logic [7:0] attack_r, decay_r;

  logic [CNT_W-1:0]   cnt_r;
  logic [NOTE_CW-1:0] note_r;
  logic [LEN_W-1:0]   pos_r;
  logic [NOTE_CW-1:0] iter_r;

  logic [STEP_W-1:0] step_rd_r;
  logic [LEN_W-1:0]  len_rd_r;

  logic [PROD_W-1:0] prod_r;
  logic [REM_W-1:0]  rem_r;
  logic [MAG_W-1:0]  q_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              sat_r;
  logic [ENV_W-1:0]  a_r;
  logic [MAG_W-1:0]  sin_mag_r;
  logic              neg_r;

  logic out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;

  logic [NOTE_CW-1:0] played;
  logic               restart;
  logic [NOTE_AW-1:0] rd_addr;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               mul_en;
  logic [ENV_W-1:0]   env_q;
  logic [REM_W-1:0]   rem_sh;
  logic [9:0]         phase_idx;
  logic [QIDX_W-1:0]  qidx;
  logic [LEN_W:0]     pos_inc;
  logic [NOTE_CW:0]   note_inc;
  logic [MAG_W-1:0]   mag;

  always_comb begin
    if (note_count_r == 7'd0) played = NOTE_CW'(1);
    else if (note_count_r > 7'(MAX_NOTES)) played = NOTE_CW'(MAX_NOTES);
    else played = NOTE_CW'(note_count_r);
  end

  assign restart = (note_r >= played);
  assign rd_addr = restart ? '0 : note_r[NOTE_AW-1:0];
  assign env_q   = sat_r ? ENV_ONE : ENV_W'(q_r);
  assign rem_sh  = {rem_r[REM_W-2:0], 1'b0};
  assign phase_idx = prod_r[23:14];
  assign qidx = phase_idx[8] ? QIDX_W'(QUARTER) - QIDX_W'(phase_idx[7:0])
                             : QIDX_W'(phase_idx[7:0]);
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign note_inc = {1'b0, note_r} + 1'b1;
  assign mag = prod_r[29:15];

  assign stat.found     = (pos_r < len_rd_r);
  assign stat.iter_last = (iter_r == played);
  assign stat.div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign stat.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b0;
    case (cmd.op)
      OP_MUL_PHASE: begin
        mul_en = 1'b1;
        mul_a = cnt_r[MUL_W-1:0];
        mul_b = step_rd_r;
      end
      OP_MUL_ATTACK: begin
        mul_en = 1'b1;
        mul_a = MUL_W'(pos_r);
        mul_b = MUL_W'(attack_r);
      end
      OP_MUL_DECAY: begin
        mul_en = 1'b1;
        mul_a = MUL_W'(len_rd_r - pos_r);
        mul_b = MUL_W'(decay_r);
      end
      OP_MUL_VOL: begin
        mul_en = 1'b1;
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(env_q);
      end
      OP_MUL_SAMPLE: begin
        mul_en = 1'b1;
        mul_a = MUL_W'(sin_mag_r);
        mul_b = MUL_W'(prod_r[30:15]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
    if (cmd.op == OP_WR) begin
      step_mem[in_note_index] <= in_phase_step;
      len_mem[in_note_index]  <= in_note_length;
    end
    if (cmd.op == OP_SCAN_RD) begin
      step_rd_r <= step_mem[rd_addr];
      len_rd_r  <= len_mem[rd_addr];
    end
    if (cmd.op == OP_MUL_ATTACK) begin
      sin_mag_r <= SINE_LUT[qidx];
      neg_r     <= phase_idx[9];
    end
    if (cmd.op == OP_DIV_INIT) begin
      sat_r  <= (prod_r[27:0] >= 28'(len_rd_r));
      rem_r  <= prod_r[REM_W-1:0];
      q_r    <= '0;
      dcnt_r <= '0;
    end
    if (cmd.op == OP_DIV_STEP) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (rem_sh >= REM_W'(len_rd_r)) begin
        rem_r <= rem_sh - REM_W'(len_rd_r);
        q_r   <= {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.op == OP_MUL_DECAY) a_r <= env_q;
    if (cmd.op == OP_FIN) out_sample_r <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (cmd.op == OP_FAIL) out_sample_r <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_count_r <= 7'd1;
      attack_r     <= 8'd32;
      decay_r      <= 8'd16;
      cnt_r        <= '0;
      note_r       <= '0;
      pos_r        <= '0;
      iter_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NOTE_COUNT:  note_count_r <= cfg_data[6:0];
          REG_ATTACK_GAIN: attack_r     <= cfg_data;
          REG_DECAY_GAIN:  decay_r      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_FIN || cmd.op == OP_FAIL) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_SCAN_INIT: iter_r <= '0;
        OP_SCAN_RD: begin
          if (restart) begin
            note_r <= '0;
            pos_r  <= '0;
            cnt_r  <= '0;
          end
        end
        OP_SCAN_CMP: begin
          if (!stat.found) begin
            note_r <= note_r + 1'b1;
            pos_r  <= '0;
            iter_r <= iter_r + 1'b1;
          end
        end
        OP_FIN: begin
          if (pos_inc >= (LEN_W+1)'(len_rd_r)) begin
            pos_r <= '0;
            if (note_inc >= (NOTE_CW+1)'(played)) begin
              note_r <= '0;
              cnt_r  <= '0;
            end else begin
              note_r <= note_inc[NOTE_CW-1:0];
              cnt_r  <= cnt_r + 1'b1;
            end
          end else begin
            pos_r <= pos_inc[LEN_W-1:0];
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// ----- src/note_sequencer_tone_generator_top.sv -----
// ----------------------------------------------------------------------------
// note_sequencer_tone_generator_top
// Looping note sequencer with sine tone and attack/decay envelope.
// A write item is stored in the cycle it is accepted. A tick item scans the
// notes (at least one) for the play position, then runs two 15-step serial
// divisions for the envelope, with one shared 24x24 multiplier for all
// products. Its result becomes valid as in_ready rises for the next item,
// and no new item is taken before then. With no playable note the result
// is zero. A held result stalls the sequencer until it is taken.
// Synchronous active-low reset clears position and counters and sets the
// registers to their defaults; the note stores are not cleared.
// ----------------------------------------------------------------------------
module note_sequencer_tone_generator_top import nstg_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [5:0]                     in_note_index,
  input  logic [23:0]                    in_phase_step,
  input  logic [19:0]                    in_note_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nstg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nstg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_note_index  (in_note_index[NOTE_AW-1:0]),
    .in_phase_step  (in_phase_step),
    .in_note_length (in_note_length),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample)
  );

endmodule
